// ===== design/ilsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_pkg
// Shared types and codes for the indexed list store: command codes, cell
// modes, controller states and the structs that run along the cell chain.
// ----------------------------------------------------------------------------
package ilsu_pkg;

    localparam int POS_W  = 13;
    localparam int DATA_W = 64;

    typedef enum logic [2:0] {
        CMD_GET     = 3'd0,
        CMD_SET     = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_DELETE  = 3'd3,
        CMD_FIND    = 3'd4,
        CMD_SWAP    = 3'd5,
        CMD_REVERSE = 3'd6,
        CMD_CLEAR   = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_SET,
        MODE_INSERT,
        MODE_DELETE,
        MODE_SWAP,
        MODE_ROTATE
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAVE,
        ST_ROT,
        ST_DONE
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic [POS_W-1:0]   idx;
        logic [POS_W-1:0]   jdx;
        logic [POS_W-1:0]   len;
        logic [DATA_W-1:0]  val;
        logic [DATA_W-1:0]  wa;
        logic [DATA_W-1:0]  wb;
    } ctl_t;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [POS_W-1:0]   fidx;
        logic [DATA_W-1:0]  vi;
        logic [DATA_W-1:0]  vj;
    } wave_t;

endpackage

// ===== design/indexed_list_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Fixed-capacity ordered list held in a chain of cells, one element per cell.
// ----------------------------------------------------------------------------
// The block takes one command item at a time and returns one result item for
// it. Set, insert and clear, and every command that fails its range check,
// go from the execute step straight to the done step, since every cell
// updates itself at once. Get, delete, find and swap send a collection wave
// down the chain, one cell per cycle, and wait for it to leave the last cell.
// Reverse on two or more elements rotates ever shorter prefixes of the list,
// one per cycle. A result that waits for m_tready holds the next item in its
// last step. The storage is CAPACITY registers of ELEM_WIDTH bits.
module indexed_list_store_unit #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // cmd, index, other_index, value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // ok, data_out, found_index, count
);

    ilsu_pkg::ctl_t        ctl;
    logic                  wave_start;
    ilsu_pkg::wave_t       wave_head;
    ilsu_pkg::wave_t       wave_chain [CAPACITY];
    logic [ELEM_WIDTH-1:0] cell_data  [CAPACITY];

    always_comb begin
        wave_head       = '0;
        wave_head.valid = wave_start;
    end

    ilsu_ctrl #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .ctl        (ctl),
        .wave_start (wave_start),
        .wave_tail  (wave_chain[CAPACITY-1])
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        ilsu_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .POS        (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .left_data  (cell_data[(k == 0) ? 0 : k - 1]),
            .right_data (cell_data[(k == CAPACITY - 1) ? k : k + 1]),
            .head_data  (cell_data[0]),
            .wave_in    ((k == 0) ? wave_head : wave_chain[(k == 0) ? 0 : k - 1]),
            .wave_out   (wave_chain[k]),
            .data_out   (cell_data[k])
        );
    end

endmodule

// ===== design/ilsu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_cell
// One list position: holds an element, updates it from its neighbors for
// shifting commands, and passes the collection wave on to the next cell.
// ----------------------------------------------------------------------------
module ilsu_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int POS        = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ilsu_pkg::ctl_t         ctl,
    input  logic [ELEM_WIDTH-1:0]  left_data,
    input  logic [ELEM_WIDTH-1:0]  right_data,
    input  logic [ELEM_WIDTH-1:0]  head_data,
    input  ilsu_pkg::wave_t        wave_in,
    output ilsu_pkg::wave_t        wave_out,
    output logic [ELEM_WIDTH-1:0]  data_out
);

    localparam logic [ilsu_pkg::POS_W-1:0] P = ilsu_pkg::POS_W'(POS);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;
    ilsu_pkg::wave_t       wave_reg;
    ilsu_pkg::wave_t       wave_next;
    logic [ELEM_WIDTH-1:0] val;

    assign val = ctl.val[ELEM_WIDTH-1:0];

    always_comb begin
        data_next = data_reg;
        case (ctl.mode)
            ilsu_pkg::MODE_SET: begin
                if (P == ctl.idx) begin
                    data_next = val;
                end
            end
            ilsu_pkg::MODE_INSERT: begin
                if (P == ctl.idx) begin
                    data_next = val;
                end else if (P > ctl.idx && P <= ctl.len) begin
                    data_next = left_data;
                end
            end
            ilsu_pkg::MODE_DELETE: begin
                if (P >= ctl.idx && (P + 1'b1) < ctl.len) begin
                    data_next = right_data;
                end
            end
            ilsu_pkg::MODE_SWAP: begin
                if (P == ctl.idx) begin
                    data_next = ctl.wa[ELEM_WIDTH-1:0];
                end
                if (P == ctl.jdx) begin
                    data_next = ctl.wb[ELEM_WIDTH-1:0];
                end
            end
            ilsu_pkg::MODE_ROTATE: begin
                if (P < ctl.idx) begin
                    data_next = right_data;
                end else if (P == ctl.idx) begin
                    data_next = head_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_comb begin
        wave_next = wave_in;
        if (wave_in.valid) begin
            if (P == ctl.idx) begin
                wave_next.vi = ilsu_pkg::DATA_W'(data_reg);
            end
            if (P == ctl.jdx) begin
                wave_next.vj = ilsu_pkg::DATA_W'(data_reg);
            end
            if (!wave_in.hit && P < ctl.len && data_reg == val) begin
                wave_next.hit  = 1'b1;
                wave_next.fidx = P;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            wave_reg.valid <= 1'b0;
        end else begin
            wave_reg.valid <= wave_next.valid;
        end
        wave_reg.hit  <= wave_next.hit;
        wave_reg.fidx <= wave_next.fidx;
        wave_reg.vi   <= wave_next.vi;
        wave_reg.vj   <= wave_next.vj;
    end

    assign wave_out = wave_reg;
    assign data_out = data_reg;

endmodule

// ===== design/ilsu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilsu_ctrl
// Command sequencer: takes items, checks ranges against the length, drives
// the cell chain and launches collection waves, and holds the result item.
// ----------------------------------------------------------------------------
module ilsu_ctrl #(
    parameter int CAPACITY   = 256,
    parameter int ELEM_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [55:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,
    output ilsu_pkg::ctl_t   ctl,
    output logic             wave_start,
    input  ilsu_pkg::wave_t  wave_tail
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int PW    = ilsu_pkg::POS_W;

    ilsu_pkg::state_t       state_reg, state_next;
    ilsu_pkg::cmd_t         cmd_reg, cmd_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       m_reg, m_next;
    logic [8:0]             idx_reg, idx_next;
    logic [7:0]             jdx_reg, jdx_next;
    logic [ELEM_WIDTH-1:0]  val_reg, val_next;
    logic                   ok_reg, ok_next;
    logic [ELEM_WIDTH-1:0]  dout_reg, dout_next;
    logic [PW-1:0]          fidx_reg, fidx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [55:0]            m_tdata_reg, m_tdata_next;

    logic [63:0]            val_wide;
    logic [63:0]            dout_wide;
    logic [PW-1:0]          idx_p;
    logic [PW-1:0]          jdx_p;
    logic [PW-1:0]          len_p;
    logic                   idx_in_range;
    logic                   jdx_in_range;

    assign val_wide     = {32'd0, s_tdata[51:20]};
    assign dout_wide    = 64'(dout_reg);
    assign idx_p        = PW'(idx_reg);
    assign jdx_p        = PW'(jdx_reg);
    assign len_p        = PW'(len_reg);
    assign idx_in_range = idx_p < len_p;
    assign jdx_in_range = jdx_p < len_p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ilsu_pkg::ST_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        m_reg       <= m_next;
        idx_reg     <= idx_next;
        jdx_reg     <= jdx_next;
        val_reg     <= val_next;
        ok_reg      <= ok_next;
        dout_reg    <= dout_next;
        fidx_reg    <= fidx_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        m_next        = m_reg;
        idx_next      = idx_reg;
        jdx_next      = jdx_reg;
        val_next      = val_reg;
        ok_next       = ok_reg;
        dout_next     = dout_reg;
        fidx_next     = fidx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wave_start    = 1'b0;
        s_tready      = 1'b0;

        ctl.mode = ilsu_pkg::MODE_NONE;
        ctl.idx  = idx_p;
        ctl.jdx  = jdx_p;
        ctl.len  = len_p;
        ctl.val  = ilsu_pkg::DATA_W'(val_reg);
        ctl.wa   = wave_tail.vj;
        ctl.wb   = wave_tail.vi;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ilsu_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next   = ilsu_pkg::cmd_t'(s_tdata[2:0]);
                    idx_next   = s_tdata[11:3];
                    jdx_next   = s_tdata[19:12];
                    val_next   = val_wide[ELEM_WIDTH-1:0];
                    state_next = ilsu_pkg::ST_EXEC;
                end
            end
            ilsu_pkg::ST_EXEC: begin
                ok_next    = 1'b0;
                dout_next  = '0;
                fidx_next  = '0;
                state_next = ilsu_pkg::ST_DONE;
                case (cmd_reg)
                    ilsu_pkg::CMD_GET, ilsu_pkg::CMD_DELETE: begin
                        if (idx_in_range) begin
                            wave_start = 1'b1;
                            state_next = ilsu_pkg::ST_WAVE;
                        end
                    end
                    ilsu_pkg::CMD_FIND: begin
                        wave_start = 1'b1;
                        state_next = ilsu_pkg::ST_WAVE;
                    end
                    ilsu_pkg::CMD_SWAP: begin
                        if (idx_in_range && jdx_in_range) begin
                            wave_start = 1'b1;
                            state_next = ilsu_pkg::ST_WAVE;
                        end
                    end
                    ilsu_pkg::CMD_SET: begin
                        if (idx_in_range) begin
                            ctl.mode = ilsu_pkg::MODE_SET;
                            ok_next  = 1'b1;
                        end
                    end
                    ilsu_pkg::CMD_INSERT: begin
                        if (idx_p <= len_p && len_p < PW'(CAPACITY)) begin
                            ctl.mode = ilsu_pkg::MODE_INSERT;
                            len_next = len_reg + 1'b1;
                            ok_next  = 1'b1;
                        end
                    end
                    ilsu_pkg::CMD_REVERSE: begin
                        ok_next = 1'b1;
                        if (len_reg > LEN_W'(1)) begin
                            m_next     = len_reg - 1'b1;
                            state_next = ilsu_pkg::ST_ROT;
                        end
                    end
                    ilsu_pkg::CMD_CLEAR: begin
                        len_next = '0;
                        ok_next  = 1'b1;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            ilsu_pkg::ST_WAVE: begin
                if (wave_tail.valid) begin
                    state_next = ilsu_pkg::ST_DONE;
                    case (cmd_reg)
                        ilsu_pkg::CMD_GET: begin
                            ok_next   = 1'b1;
                            dout_next = wave_tail.vi[ELEM_WIDTH-1:0];
                        end
                        ilsu_pkg::CMD_DELETE: begin
                            ctl.mode  = ilsu_pkg::MODE_DELETE;
                            len_next  = len_reg - 1'b1;
                            ok_next   = 1'b1;
                            dout_next = wave_tail.vi[ELEM_WIDTH-1:0];
                        end
                        ilsu_pkg::CMD_SWAP: begin
                            ctl.mode = ilsu_pkg::MODE_SWAP;
                            ok_next  = 1'b1;
                        end
                        default: begin
                            ok_next   = wave_tail.hit;
                            fidx_next = wave_tail.hit ? wave_tail.fidx : '0;
                        end
                    endcase
                end
            end
            ilsu_pkg::ST_ROT: begin
                ctl.mode = ilsu_pkg::MODE_ROTATE;
                ctl.idx  = PW'(m_reg);
                m_next   = m_reg - 1'b1;
                if (m_reg == LEN_W'(1)) begin
                    state_next = ilsu_pkg::ST_DONE;
                end
            end
            ilsu_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, 9'(len_reg), fidx_reg[7:0],
                                     dout_wide[31:0], ok_reg};
                    state_next    = ilsu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ilsu_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for indexed_list_store_unit. A short table of
// commands covers the empty list, the range limits and the rejected cases.
// Random command mixes follow, including one fill of the list to capacity.
// The shadow list, or a typed table row, predicts each result, which is compared
// field by field with what the block returns, under varying backpressure.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY    = 256;
    localparam int ELEM_WIDTH  = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_ROWS    = 26;
    localparam int EXP_DEPTH   = 16;

    typedef struct packed {
        logic [31:0]      value;
        logic [7:0]       other_index;
        logic [8:0]       index;
        ilsu_pkg::cmd_t   cmd;
    } list_cmd_t;

    typedef struct packed {
        logic [8:0]  count;
        logic [7:0]  found_index;
        logic [31:0] data_out;
        logic        ok;
    } list_result_t;

    typedef struct packed {
        ilsu_pkg::cmd_t cmd;
        logic [8:0]     index;
        logic [7:0]     other_index;
        logic [31:0]    value;
        logic           typed;
        logic           ok;
        logic [31:0]    data_out;
        logic [7:0]     found_index;
        logic [8:0]     count;
    } table_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // cmd, index, other_index, value
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // ok, data_out, found_index, count

    logic [31:0]  shadow_list [CAPACITY];
    int           shadow_len = 0;
    list_result_t expected_results [EXP_DEPTH];
    int           exp_wr = 0;
    int           exp_rd = 0;

    int tx_idle_pct = 21;
    int rx_idle_pct = 85;
    int hold_reqs   = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int full_rejects    = 0;

    table_row_t command_table [NUM_ROWS] = '{
        '{ilsu_pkg::CMD_GET, 9'd0, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_DELETE, 9'd0, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_SWAP, 9'd0, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_FIND, 9'd0, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_REVERSE, 9'd0, 8'd0, 32'd0, 1'b1, 1'b1, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_INSERT, 9'd1, 8'd0, 32'd5, 1'b1, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_INSERT, 9'd0, 8'd0, 32'hFFFFFFFF, 1'b1, 1'b1, 32'd0, 8'd0, 9'd1},
        '{ilsu_pkg::CMD_GET, 9'd0, 8'd0, 32'd0, 1'b1, 1'b1, 32'hFFFFFFFF, 8'd0, 9'd1},
        '{ilsu_pkg::CMD_INSERT, 9'd1, 8'd0, 32'd0, 1'b1, 1'b1, 32'd0, 8'd0, 9'd2},
        '{ilsu_pkg::CMD_INSERT, 9'd0, 8'd0, 32'h12345678, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_GET, 9'd256, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd3},
        '{ilsu_pkg::CMD_SET, 9'd256, 8'd0, 32'd1, 1'b1, 1'b0, 32'd0, 8'd0, 9'd3},
        '{ilsu_pkg::CMD_SET, 9'd2, 8'd0, 32'hA5A5A5A5, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_FIND, 9'd0, 8'd0, 32'hFFFFFFFF, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_FIND, 9'd0, 8'd0, 32'hDEADBEEF, 1'b1, 1'b0, 32'd0, 8'd0, 9'd3},
        '{ilsu_pkg::CMD_SWAP, 9'd0, 8'd255, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd3},
        '{ilsu_pkg::CMD_SWAP, 9'd0, 8'd2, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_REVERSE, 9'd0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_GET, 9'd0, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_GET, 9'd2, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_DELETE, 9'd1, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_DELETE, 9'd256, 8'd0, 32'd0, 1'b1, 1'b0, 32'd0, 8'd0, 9'd2},
        '{ilsu_pkg::CMD_INSERT, 9'd2, 8'd0, 32'h0F0F0F0F, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_DELETE, 9'd2, 8'd0, 32'd0, 1'b0, 1'b0, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_CLEAR, 9'd0, 8'd0, 32'd0, 1'b1, 1'b1, 32'd0, 8'd0, 9'd0},
        '{ilsu_pkg::CMD_CLEAR, 9'd0, 8'd0, 32'd0, 1'b1, 1'b1, 32'd0, 8'd0, 9'd0}
    };

    indexed_list_store_unit #(
        .CAPACITY   (CAPACITY),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic list_result_t apply_list_cmd(list_cmd_t c);
        list_result_t r;
        logic [31:0]  t;
        int           k;
        int           lo;
        int           hi;
        r = '0;
        case (c.cmd)
            ilsu_pkg::CMD_GET: begin
                if (c.index < shadow_len) begin
                    r.data_out = shadow_list[8'(c.index)];
                    r.ok = 1'b1;
                end
            end
            ilsu_pkg::CMD_SET: begin
                if (c.index < shadow_len) begin
                    shadow_list[8'(c.index)] = c.value;
                    r.ok = 1'b1;
                end
            end
            ilsu_pkg::CMD_INSERT: begin
                if (c.index <= shadow_len && shadow_len < CAPACITY) begin
                    for (k = shadow_len; k > c.index; k--)
                        shadow_list[8'(k)] = shadow_list[8'(k-1)];
                    shadow_list[8'(c.index)] = c.value;
                    shadow_len++;
                    r.ok = 1'b1;
                end
            end
            ilsu_pkg::CMD_DELETE: begin
                if (c.index < shadow_len) begin
                    r.data_out = shadow_list[8'(c.index)];
                    for (k = c.index; k + 1 < shadow_len; k++)
                        shadow_list[8'(k)] = shadow_list[8'(k+1)];
                    shadow_len--;
                    r.ok = 1'b1;
                end
            end
            ilsu_pkg::CMD_FIND: begin
                for (k = 0; k < shadow_len; k++) begin
                    if (!r.ok && shadow_list[8'(k)] == c.value) begin
                        r.ok = 1'b1;
                        r.found_index = 8'(k);
                    end
                end
            end
            ilsu_pkg::CMD_SWAP: begin
                if (c.index < shadow_len && c.other_index < shadow_len) begin
                    t = shadow_list[8'(c.index)];
                    shadow_list[8'(c.index)] = shadow_list[c.other_index];
                    shadow_list[c.other_index] = t;
                    r.ok = 1'b1;
                end
            end
            ilsu_pkg::CMD_REVERSE: begin
                lo = 0;
                hi = shadow_len - 1;
                while (lo < hi) begin
                    t = shadow_list[8'(lo)];
                    shadow_list[8'(lo)] = shadow_list[8'(hi)];
                    shadow_list[8'(hi)] = t;
                    lo++;
                    hi--;
                end
                r.ok = 1'b1;
            end
            default: begin
                shadow_len = 0;
                r.ok = 1'b1;
            end
        endcase
        r.count = 9'(shadow_len);
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            5: v = 32'd0;
            6: v = 32'hFFFFFFFF;
            7: v = $urandom_range(0, 3);
            8, 9: v = (shadow_len > 0) ? shadow_list[8'($urandom_range(0, shadow_len - 1))]
                                       : $urandom;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // The roll selects the command: 0..29 insert, 30..44 delete, 45..59 get,
    // 60..69 set, 70..81 find, 82..91 swap, 92..96 reverse and 97 and up clear.
    function automatic list_cmd_t gen_list_cmd(int roll);
        list_cmd_t c;
        int        span;
        if (roll < 30)
            c.cmd = ilsu_pkg::CMD_INSERT;
        else if (roll < 45)
            c.cmd = ilsu_pkg::CMD_DELETE;
        else if (roll < 60)
            c.cmd = ilsu_pkg::CMD_GET;
        else if (roll < 70)
            c.cmd = ilsu_pkg::CMD_SET;
        else if (roll < 82)
            c.cmd = ilsu_pkg::CMD_FIND;
        else if (roll < 92)
            c.cmd = ilsu_pkg::CMD_SWAP;
        else if (roll < 97)
            c.cmd = ilsu_pkg::CMD_REVERSE;
        else
            c.cmd = ilsu_pkg::CMD_CLEAR;
        c.value = pick_value();
        if (shadow_len > 0 && $urandom_range(0, 9) != 0)
            c.other_index = 8'($urandom_range(0, shadow_len - 1));
        else
            c.other_index = 8'($urandom_range(0, 255));
        span = (c.cmd == ilsu_pkg::CMD_INSERT) ? shadow_len : shadow_len - 1;
        if (span < 0)
            span = 0;
        case ($urandom_range(0, 9))
            0: c.index = 9'($urandom_range(0, 511));
            1: c.index = 9'd0;
            2: c.index = 9'(span);
            default: c.index = 9'($urandom_range(0, span));
        endcase
        return c;
    endfunction

    task automatic send_item(input list_cmd_t c, input logic typed, input list_result_t typed_res);
        list_result_t pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, c};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pred = apply_list_cmd(c);
        expected_results[exp_wr[3:0]] = typed ? typed_res : pred;
        exp_wr++;
        items_sent++;
        if (c.cmd == ilsu_pkg::CMD_INSERT && !pred.ok && pred.count == CAPACITY)
            full_rejects++;
        @(negedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
        errors++;
    endtask

    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        list_result_t want_res;
        list_result_t got_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("result with no command pending", 64'(m_tdata), '0);
            end else begin
                want_res = expected_results[exp_rd[3:0]];
                exp_rd++;
                got_res  = m_tdata[49:0];
                if (got_res.ok !== want_res.ok)
                    report_mismatch("ok", 64'(got_res.ok), 64'(want_res.ok));
                if (got_res.data_out !== want_res.data_out)
                    report_mismatch("data_out", 64'(got_res.data_out),
                                    64'(want_res.data_out));
                if (got_res.found_index !== want_res.found_index)
                    report_mismatch("found_index", 64'(got_res.found_index),
                                    64'(want_res.found_index));
                if (got_res.count !== want_res.count)
                    report_mismatch("count", 64'(got_res.count), 64'(want_res.count));
                if (m_tdata[55:50] !== 6'd0)
                    report_mismatch("padding", 64'(m_tdata[55:50]), '0);
                results_checked++;
            end
        end
    end

    initial begin
        #10ms;
        $display("Timeout with %0d results still pending", exp_wr - exp_rd);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        list_cmd_t    dc;
        list_result_t dr;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            dc.cmd         = command_table[i].cmd;
            dc.index       = command_table[i].index;
            dc.other_index = command_table[i].other_index;
            dc.value       = command_table[i].value;
            dr.ok          = command_table[i].ok;
            dr.data_out    = command_table[i].data_out;
            dr.found_index = command_table[i].found_index;
            dr.count       = command_table[i].count;
            send_item(dc, command_table[i].typed, dr);
        end

        repeat (100)
            send_item(gen_list_cmd($urandom_range(0, 99)), 1'b0, '0);

        tx_idle_pct = 85;
        rx_idle_pct = 21;
        while (shadow_len < CAPACITY)
            send_item(gen_list_cmd(0), 1'b0, '0);
        repeat (6)
            send_item(gen_list_cmd(0), 1'b0, '0);
        repeat (60)
            send_item(gen_list_cmd($urandom_range(0, 99)), 1'b0, '0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_reqs++;
        repeat (110)
            send_item(gen_list_cmd($urandom_range(0, 99)), 1'b0, '0);
        s_tvalid <= 1'b0;

        while (exp_wr != exp_rd)
            @(posedge aclk);
        repeat (CAPACITY + 16) @(posedge aclk);

        $display("Sent %0d command items: directed table, random mixes, one fill to capacity.",
                 items_sent);
        $display("Checked %0d results; %0d inserts were rejected on a full list.",
                 results_checked, full_rejects);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
